@@ src/sv39w_pkg.sv @@
// Shared types and constants for the Sv39 page table walker.
// Used by sv39w_step and sv39_page_table_walker; depends on nothing.
package sv39w_pkg;

    localparam int IDX_BITS   = 9;
    localparam int PAGE_SHIFT = 12;
    localparam int PPN_W      = 44;
    localparam int ADDR_W     = 56;
    localparam int LEVEL_W    = 2;

    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_RESPONSE  = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [2:0] STATUS_OK           = 3'd0;
    localparam logic [2:0] STATUS_ADDR_HIGH    = 3'd1;
    localparam logic [2:0] STATUS_UPPER_INVAL  = 3'd2;
    localparam logic [2:0] STATUS_LEAF_INVAL   = 3'd3;
    localparam logic [2:0] STATUS_NOT_USER     = 3'd4;

    localparam int PTE_VALID_BIT = 0;
    localparam int PTE_USER_BIT  = 4;
    localparam int PTE_PPN_LSB   = 10;

    typedef struct packed {
        logic        operation;
        logic [63:0] virt_addr;
        logic [63:0] read_data;
    } in_item_t;

    typedef struct packed {
        logic              result_kind;
        logic [ADDR_W-1:0] read_addr;
        logic [ADDR_W-1:0] phys_addr;
        logic [2:0]        status;
    } out_item_t;

    typedef struct packed {
        logic               busy;
        logic [LEVEL_W-1:0] level;
    } walk_ctrl_t;

endpackage

@@ src/sv39w_step.sv @@
// One walker step: decodes a request or a PTE response against the walk state.
// Purely combinational; depends on sv39w_pkg.
module sv39w_step
    import sv39w_pkg::*;
#(
    parameter int LEVELS = 3
)
(
    input  in_item_t                   item,
    input  walk_ctrl_t                 ctrl,
    input  logic [IDX_BITS*LEVELS-1:0] indexes,
    input  logic [PPN_W-1:0]           root_ppn,
    output logic                       has_result,
    output out_item_t                  result,
    output walk_ctrl_t                 ctrl_next,
    output logic [IDX_BITS*LEVELS-1:0] indexes_next
);

    localparam int IDXS_W    = IDX_BITS * LEVELS;
    localparam int TOP_SHIFT = PAGE_SHIFT + IDXS_W - 1;

    logic [IDXS_W-1:0]   new_indexes;
    logic [LEVEL_W-1:0]  lower_level;
    logic [IDXS_W-1:0]   root_shifted;
    logic [IDXS_W-1:0]   lower_shifted;
    logic [IDX_BITS-1:0] root_idx;
    logic [IDX_BITS-1:0] lower_idx;
    logic [PPN_W-1:0]    pte_ppn;
    logic                addr_high;

    assign new_indexes   = item.virt_addr[PAGE_SHIFT +: IDXS_W];
    assign lower_level   = ctrl.level - LEVEL_W'(1);
    assign root_shifted  = new_indexes >> (IDX_BITS * (LEVELS - 1));
    assign lower_shifted = indexes >> (IDX_BITS * int'(lower_level));
    assign root_idx      = root_shifted[IDX_BITS-1:0];
    assign lower_idx     = lower_shifted[IDX_BITS-1:0];
    assign pte_ppn       = item.read_data[PTE_PPN_LSB +: PPN_W];
    assign addr_high     = (item.virt_addr >> TOP_SHIFT) != 64'd0;

    always_comb
    begin
        has_result   = 1'b0;
        result       = '0;
        ctrl_next    = ctrl;
        indexes_next = indexes;
        if (item.operation == OP_TRANSLATE)
        begin
            has_result = 1'b1;
            if (addr_high)
            begin
                ctrl_next.busy     = 1'b0;
                result.result_kind = KIND_DONE;
                result.status      = STATUS_ADDR_HIGH;
            end
            else
            begin
                ctrl_next.busy     = 1'b1;
                ctrl_next.level    = LEVEL_W'(LEVELS - 1);
                indexes_next       = new_indexes;
                result.result_kind = KIND_READ;
                result.read_addr   = {root_ppn, root_idx, 3'b000};
            end
        end
        else if (ctrl.busy)
        begin
            has_result = 1'b1;
            if (ctrl.level != '0)
            begin
                if (!item.read_data[PTE_VALID_BIT])
                begin
                    ctrl_next.busy     = 1'b0;
                    result.result_kind = KIND_DONE;
                    result.status      = STATUS_UPPER_INVAL;
                end
                else
                begin
                    ctrl_next.level    = lower_level;
                    result.result_kind = KIND_READ;
                    result.read_addr   = {pte_ppn, lower_idx, 3'b000};
                end
            end
            else
            begin
                ctrl_next.busy     = 1'b0;
                result.result_kind = KIND_DONE;
                if (!item.read_data[PTE_VALID_BIT])
                begin
                    result.status = STATUS_LEAF_INVAL;
                end
                else if (!item.read_data[PTE_USER_BIT])
                begin
                    result.status = STATUS_NOT_USER;
                end
                else
                begin
                    result.status    = STATUS_OK;
                    result.phys_addr = {pte_ppn, {PAGE_SHIFT{1'b0}}};
                end
            end
        end
    end

endmodule

@@ src/sv39_page_table_walker.sv @@
// Top level of the read-only Sv39 page table walker: input register, walk state,
// result register and the root table register. Depends on sv39w_pkg and sv39w_step.
//
// Usage. The in channel carries two kinds of request: a translate request
// (operation 0, virt_addr) and a memory response carrying a PTE (operation 1,
// read_data). Every translate request and every response that arrives during a
// walk yields exactly one request on the out channel: either a PTE read request
// (result_kind 0, read_addr) that the system must answer with a response, or a
// finished translation (result_kind 1, phys_addr and status). A response that
// arrives while no walk is in progress is dropped without a result. A new
// translate request abandons any walk in progress.
// An accepted request sits in the input register and is decoded into the result
// register once that register is free or being emptied; the out channel is driven
// from the result register. Throughput is one request per cycle while out_stall is
// low, set by the combinational decode step between the two registers; memory
// latency lies outside the block. When out_stall holds the result register, the
// input register can still take one request, after which in_stall rises. Reset
// clears all valids, leaves the walker idle and clears root_table_ppn. The root
// register is written through the cfg channel, which is always ready, and must
// only be written while the walker is idle.
module sv39_page_table_walker
    import sv39w_pkg::*;
#(
    parameter int LEVELS = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_item,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [PPN_W-1:0] cfg_data
);

    localparam int IDXS_W = IDX_BITS * LEVELS;

    // Request waiting for its decode step.
    logic        in_valid_reg;
    in_item_t    in_item_reg;

    // Walk state, updated only when a request is decoded.
    walk_ctrl_t        ctrl_reg;
    walk_ctrl_t        ctrl_next;
    logic [IDXS_W-1:0] indexes_reg;
    logic [IDXS_W-1:0] indexes_next;

    logic [PPN_W-1:0] root_table_ppn_reg;

    // Result register.
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic      step_has_result;
    out_item_t step_result;
    logic      advance;
    logic      in_accept;

    // The decode step runs whenever the result register is free or being emptied.
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    sv39w_step #(
        .LEVELS (LEVELS)
    ) u_step (
        .item         (in_item_reg),
        .ctrl         (ctrl_reg),
        .indexes      (indexes_reg),
        .root_ppn     (root_table_ppn_reg),
        .has_result   (step_has_result),
        .result       (step_result),
        .ctrl_next    (ctrl_next),
        .indexes_next (indexes_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            ctrl_reg           <= '0;
            indexes_reg        <= '0;
            root_table_ppn_reg <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= step_has_result;
                ctrl_reg      <= ctrl_next;
                indexes_reg   <= indexes_next;
            end

            if (cfg_valid && cfg_ready)
            begin
                root_table_ppn_reg <= cfg_data;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg <= in_item;
        end
        if (advance && step_has_result)
        begin
            out_item_reg <= step_result;
        end
    end

    // A pending PTE read request always belongs to a walk still in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.result_kind == KIND_READ |-> ctrl_reg.busy)
    else $error("read request pending while walker idle");

    // A finished translation never carries a read address.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.result_kind == KIND_DONE |-> out_item.read_addr == '0)
    else $error("finished result with nonzero read address");

    // The input side only backs up behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

    // A decoded request with no result must leave the walk state untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !step_has_result |=> $stable(ctrl_reg) && $stable(indexes_reg))
    else $error("dropped response changed walk state");

endmodule

@@ tb/sv39w_checker.sv @@
// Scoreboard for the Sv39 page table walker: watches the in, out and cfg channels.
// Predicts every result from its own copy of the walk state. Depends on sv39w_pkg.
`timescale 1ns / 1ps

module sv39w_checker
    import sv39w_pkg::*;
#(
    parameter int LEVELS = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  in_item_t         in_item,
    input  logic             out_valid,
    input  logic             out_stall,
    input  out_item_t        out_item,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [PPN_W-1:0] cfg_data,
    output int               fail_count,
    output int               pending
);

    localparam int IDX_ALL   = IDX_BITS * LEVELS;
    localparam int TOP_SHIFT = PAGE_SHIFT + IDX_ALL - 1;

    logic [PPN_W-1:0]   root_ppn;
    logic               walking;
    logic [LEVEL_W-1:0] cur_level;
    logic [IDX_ALL-1:0] va_indexes;
    out_item_t          expected_q[$];

    // Byte address of the entry for one level inside a table.
    function automatic logic [ADDR_W-1:0] entry_addr(input logic [ADDR_W-1:0] table_base,
                                                     input logic [LEVEL_W-1:0] lvl);
        logic [IDX_ALL-1:0] shifted;
        shifted = va_indexes >> (IDX_BITS * lvl);
        return table_base + ADDR_W'({shifted[IDX_BITS-1:0], 3'b000});
    endfunction

    task automatic predict_walk(input in_item_t req);
        out_item_t         want;
        logic [ADDR_W-1:0] next_base;
        want = '0;
        if (req.operation == OP_TRANSLATE) begin
            if (req.virt_addr[63:TOP_SHIFT] != '0) begin
                walking          = 1'b0;
                want.result_kind = KIND_DONE;
                want.status      = STATUS_ADDR_HIGH;
            end
            else begin
                va_indexes       = req.virt_addr[PAGE_SHIFT +: IDX_ALL];
                cur_level        = LEVEL_W'(LEVELS - 1);
                walking          = 1'b1;
                want.result_kind = KIND_READ;
                want.read_addr   = entry_addr({root_ppn, {PAGE_SHIFT{1'b0}}}, cur_level);
            end
            expected_q.push_back(want);
        end
        else if (walking) begin
            next_base = {req.read_data[PTE_PPN_LSB +: PPN_W], {PAGE_SHIFT{1'b0}}};
            if (cur_level != '0) begin
                if (!req.read_data[PTE_VALID_BIT]) begin
                    walking          = 1'b0;
                    want.result_kind = KIND_DONE;
                    want.status      = STATUS_UPPER_INVAL;
                end
                else begin
                    cur_level        = cur_level - LEVEL_W'(1);
                    want.result_kind = KIND_READ;
                    want.read_addr   = entry_addr(next_base, cur_level);
                end
            end
            else begin
                walking          = 1'b0;
                want.result_kind = KIND_DONE;
                if (!req.read_data[PTE_VALID_BIT])
                    want.status = STATUS_LEAF_INVAL;
                else if (!req.read_data[PTE_USER_BIT])
                    want.status = STATUS_NOT_USER;
                else
                    want.phys_addr = next_base;
            end
            expected_q.push_back(want);
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (expected_q.size() == 0) begin
            $error("result_kind mismatch: expected none, actual 0x%0h", got.result_kind);
            fail_count++;
            return;
        end
        want = expected_q.pop_front();
        compare_field("result_kind", 64'(want.result_kind), 64'(got.result_kind));
        compare_field("read_addr", 64'(want.read_addr), 64'(got.read_addr));
        compare_field("phys_addr", 64'(want.phys_addr), 64'(got.phys_addr));
        compare_field("status", 64'(want.status), 64'(got.status));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            root_ppn   = '0;
            walking    = 1'b0;
            cur_level  = '0;
            va_indexes = '0;
            expected_q.delete();
            fail_count = 0;
        end
        else begin
            if (out_valid && !out_stall)
                check_result(out_item);
            if (cfg_valid && cfg_ready)
                root_ppn = cfg_data;
            if (in_valid && !in_stall)
                predict_walk(in_item);
        end
        pending = expected_q.size();
    end

endmodule

@@ tb/sv39_page_table_walker_tb.sv @@
// Top of the Sv39 page table walker testbench: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on sv39w_pkg, sv39w_checker and the RTL.
`timescale 1ns / 1ps

module sv39_page_table_walker_tb;
    import sv39w_pkg::*;

    localparam int LEVELS      = 3;
    // Highest virtual address bit that may be set without faulting, plus one.
    localparam int VA_TOP      = PAGE_SHIFT + IDX_BITS * LEVELS - 1;
    localparam int PHASE_ITEMS = 450;
    localparam int HOLD_CYCLES = 80;
    // The block has two register stages; the extra settle time covers any dropped response.
    localparam int SETTLE      = 8;
    localparam int TIMEOUT_NS  = 5_000_000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    in_item_t         in_item   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_item_t        out_item;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [PPN_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;

    // Requests accepted so far, and how many of them count toward the current phase.
    int sent_items  = 0;
    int phase_items = 0;
    // Remaining requests of a no-gap stretch on each side.
    int send_quiet  = 0;
    int recv_quiet  = 0;
    // Raised by the pressure process to hold the result channel off for a long stretch.
    bit hold_off    = 1'b0;

    always #5 clk = ~clk;

    sv39_page_table_walker #(
        .LEVELS(LEVELS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    sv39w_checker #(
        .LEVELS(LEVELS)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // A virtual address that passes the range check: VA_TOP and every bit above it are zero.
    function automatic logic [63:0] low_va();
        logic [63:0] va;
        va = rand64();
        va[63:VA_TOP] = '0;
        return va;
    endfunction

    // A virtual address with at least one bit set at or above VA_TOP.
    function automatic logic [63:0] high_va();
        logic [63:0] va;
        va = rand64();
        va[$urandom_range(63, VA_TOP)] = 1'b1;
        return va;
    endfunction

    // A page table entry with random PPN and flag bits, apart from V and U.
    function automatic logic [63:0] make_pte(input bit valid, input bit user);
        logic [63:0] pte;
        pte = rand64();
        pte[PTE_VALID_BIT] = valid;
        pte[PTE_USER_BIT]  = user;
        return pte;
    endfunction

    // The field that the request does not use carries noise, so the block must ignore it.
    function automatic in_item_t translate_req(input logic [63:0] va);
        in_item_t req;
        req.operation = OP_TRANSLATE;
        req.virt_addr = va;
        req.read_data = rand64();
        return req;
    endfunction

    function automatic in_item_t response_req(input logic [63:0] pte);
        in_item_t req;
        req.operation = OP_RESPONSE;
        req.virt_addr = rand64();
        req.read_data = pte;
        return req;
    endfunction

    // Offers one request after a random gap and returns just after the edge that takes it.
    // The stall is looked at on the falling edge, where it has settled, so the acceptance
    // edge is known without racing the block's own updates.
    task automatic offer(input in_item_t req, input bit counts);
        int gap;
        if (send_quiet > 0) begin
            gap = 0;
            send_quiet--;
        end
        else begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 39) == 0)
                send_quiet = $urandom_range(16, 48);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        sent_items++;
        if (counts)
            phase_items++;
    endtask

    // A walk from translate request to leaf, with random content. Now and then an upper
    // entry is invalid, the leaf fails a check, or the walk is left hanging so that the
    // next translate request abandons it.
    task automatic random_walk();
        bit ok;
        offer(translate_req(low_va()), 1'b1);
        for (int lvl = LEVELS - 1; lvl >= 0; lvl--) begin
            if ($urandom_range(0, 19) == 0)
                return;
            if (lvl > 0) begin
                ok = ($urandom_range(0, 11) != 0);
                offer(response_req(make_pte(ok, 1'($urandom_range(0, 1)))), 1'b1);
                if (!ok)
                    return;
            end
            else begin
                offer(response_req(make_pte($urandom_range(0, 9) != 0,
                                            $urandom_range(0, 6) != 0)), 1'b1);
            end
        end
    endtask

    // Ends any walk with an out-of-range translate request, then waits until every
    // predicted result has been taken and the pipeline has settled.
    task automatic drain();
        offer(translate_req(64'hFFFF_FFFF_FFFF_FFFF), 1'b0);
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_root(input logic [PPN_W-1:0] ppn);
        cfg_valid <= 1'b1;
        cfg_data  <= ppn;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stimulus: directed requests with the root at its maximum, then random phases
    // under different root tables, each written while the walker sits idle.
    initial
    begin
        logic [63:0]      raw;
        logic [PPN_W-1:0] roots[4];
        int               pick;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A maximal root sets every PPN bit of the table base in the first read address.
        write_root('1);

        // A response with no walk in progress is dropped.
        offer(response_req(rand64()), 1'b0);
        // Lowest address, then entries with all PPN bits set or clear, leaf at the top page.
        offer(translate_req(64'd0), 1'b1);
        offer(response_req(64'hFFFF_FFFF_FFFF_FFFF), 1'b1);
        offer(response_req(64'h0000_0000_0000_0001), 1'b1);
        offer(response_req(64'hFFFF_FFFF_FFFF_FFFF), 1'b1);
        // Highest legal address; an all-zero top entry ends the walk as upper invalid.
        offer(translate_req((64'd1 << VA_TOP) - 1), 1'b1);
        offer(response_req(64'd0), 1'b1);
        // The walk has ended, so this response is dropped.
        offer(response_req(rand64()), 1'b0);
        // Just out of range, and every bit set.
        offer(translate_req(64'd1 << VA_TOP), 1'b1);
        offer(translate_req(64'hFFFF_FFFF_FFFF_FFFF), 1'b1);
        // Leaf with U set but V clear.
        offer(translate_req(64'd1 << (VA_TOP - 1)), 1'b1);
        offer(response_req(64'h0000_0000_0000_0001), 1'b1);
        offer(response_req(64'h0000_0000_0000_0001), 1'b1);
        offer(response_req(64'h0000_0000_0000_0010), 1'b1);
        // Leaf valid but not user accessible.
        offer(translate_req(low_va()), 1'b1);
        offer(response_req(64'hFFFF_FFFF_FFFF_FFFF), 1'b1);
        offer(response_req(64'hFFFF_FFFF_FFFF_FFFF), 1'b1);
        offer(response_req(~64'h0000_0000_0000_0010), 1'b1);
        // A new translate request in the middle of a walk; the new walk ends at page 0.
        offer(translate_req(low_va()), 1'b1);
        offer(response_req(make_pte(1'b1, 1'b0)), 1'b1);
        offer(translate_req(low_va()), 1'b1);
        offer(response_req(64'h0000_0000_0000_0011), 1'b1);
        offer(response_req(64'h0000_0000_0000_0011), 1'b1);
        offer(response_req(64'h0000_0000_0000_0011), 1'b1);
        // Invalid entry one level above the leaf.
        offer(translate_req(low_va()), 1'b1);
        offer(response_req(64'hFFFF_FFFF_FFFF_FFFF), 1'b1);
        offer(response_req(~64'h0000_0000_0000_0001), 1'b1);
        drain();

        raw      = rand64();
        roots[0] = '0;
        roots[1] = raw[PPN_W-1:0];
        roots[2] = '1;
        raw      = rand64();
        roots[3] = raw[PPN_W-1:0];

        foreach (roots[p]) begin
            write_root(roots[p]);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    random_walk();
                else if (pick < 85)
                    offer(translate_req(high_va()), 1'b1);
                else if (pick < 95)
                    offer(response_req(rand64()), 1'b0);
                else
                    offer(translate_req(rand64()), 1'b1);
            end
            drain();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Result side: before each result the stall stays high for a random number of
    // cycles, or for as long as the pressure process holds it off.
    initial
    begin
        int stall_cycles;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (recv_quiet > 0) begin
                stall_cycles = 0;
                recv_quiet--;
            end
            else begin
                stall_cycles = $urandom_range(0, 8);
                if ($urandom_range(0, 39) == 0)
                    recv_quiet = $urandom_range(16, 48);
            end
            if (stall_cycles > 0 || hold_off) begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
                while (hold_off) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(negedge clk); while (!out_valid);
            @(posedge clk);
        end
    end

    // Midway through the run the result side is held off long enough for both
    // registers to fill, so that in_stall has to rise while requests keep coming.
    initial
    begin
        wait (sent_items >= 500);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
